>>> hw/rtl/atcl_pkg.sv
// Shared types and character constants for the AT command line receiver.
package atcl_pkg;

	// input word kinds (s_tuser)
	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_T_UP = 8'h54;
	localparam logic [7:0] CH_T_LO = 8'h74;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_QM   = 8'h3F;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_BS   = 8'h08;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_WAIT_A,
		PH_WAIT_T,
		PH_LINE,
		PH_HOLD
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_STORED    = 3'd1,
		EV_REMOVED   = 3'd2,
		EV_READY     = 3'd3,
		EV_MALFORMED = 3'd4,
		EV_OVERFLOW  = 3'd5,
		EV_TIMEOUT   = 3'd6
	} ev_t;

	typedef struct packed {
		ev_t        evt;
		logic [7:0] stored_byte;
		logic [5:0] position;
		logic [6:0] name_length;
		logic [6:0] line_length;
		logic       is_read_query;
		logic       is_plain;
	} result_t;

endpackage

>>> hw/rtl/at_command_line_receiver_top.sv
// Top level of the AT command line receiver.
// Takes one word per cycle: a received UART byte, a time tick or a release
// (kind in s_tuser). Each accepted word yields exactly one result word:
// it is caught in the input register, run through the combinational step
// logic of atcl_ctrl, and the result lands in the output
// register. Throughput is one word per clock as long as m_tready is high;
// the input register refills in the same cycle the result register drains,
// so a stalled consumer backs up at most one word on each stage.
// The receiver looks for a case-insensitive "AT" prefix, then emits store
// and remove actions for an external line store (position is its index),
// flags '=' on an empty line, a misplaced '?' and a full line as errors,
// and reports command ready on CR with name length, line length and the
// read-query / plain flags. After command ready it ignores bytes until a
// release word. Ticks while the prefix or the line is open count idle
// time; a count beyond timeout_ticks drops the line with a timeout result.
// timeout_ticks (reset 1000) is written through cfg_valid/cfg_data, by the user
// only while no word is in flight (not enforced); cfg_ready is always high.
module at_command_line_receiver_top #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic [7:0]  s_tuser,   // [1:0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] stored_byte, [13:8] position, [20:14] name_length,
	// [27:21] line_length, [28] is_read_query, [29] is_plain
	output logic [31:0] m_tdata,
	output logic [7:0]  m_tuser,   // [2:0] event_res
	// configuration: timeout_ticks
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import atcl_pkg::*;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  byte_s1;
	logic        s2_ready;
	logic        adv;
	logic [15:0] timeout_q;
	result_t     step_res;

	// step fires when the result register can take the outcome
	assign adv       = valid_s1 && s2_ready;
	assign s_tready  = !valid_s1 || s2_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser[1:0];
			byte_s1 <= s_tdata;
		end
	end

	atcl_ctrl #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.op           (op_s1),
		.byte_in      (byte_s1),
		.timeout_ticks(timeout_q),
		.res          (step_res)
	);

	atcl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (step_res),
		.load_ready(s2_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> hw/rtl/atcl_ctrl.sv
// Line receiver state machine: state registers and the per-word step logic.
module atcl_ctrl #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [1:0]        op,
	input  logic [7:0]        byte_in,
	input  logic [15:0]       timeout_ticks,
	output atcl_pkg::result_t res
);
	import atcl_pkg::*;

	localparam int CW = $clog2(LINE_CAPACITY + 1);

	phase_t          phase_q, phase_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   name_q, name_d;
	logic            read_q, read_d;
	logic            plain_q, plain_d;
	logic [15:0]     idle_q, idle_d;
	logic            drop;

	logic [CW-1:0]   count_dec;
	logic [CW-1:0]   name_ready;
	logic [15:0]     idle_inc;
	logic [31:0]     pos_w;
	logic [31:0]     nl_w;
	logic [31:0]     ll_w;
	logic [31:0]     dec_w;

	assign count_dec  = count_q - CW'(1);
	assign name_ready = (name_q == '0) ? count_q : name_q;
	assign idle_inc   = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
	assign pos_w      = 32'(count_q);
	assign dec_w      = 32'(count_dec);
	assign nl_w       = 32'(name_ready);
	assign ll_w       = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_A;
			count_q <= '0;
			name_q  <= '0;
			read_q  <= 1'b0;
			plain_q <= 1'b1;
			idle_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			name_q  <= name_d;
			read_q  <= read_d;
			plain_q <= plain_d;
			idle_q  <= idle_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		name_d  = name_q;
		read_d  = read_q;
		plain_d = plain_q;
		idle_d  = idle_q;
		drop    = 1'b0;
		res     = '0;
		res.evt = EV_NONE;

		unique case (op)
			OP_BYTE: begin
				unique case (phase_q)
					PH_WAIT_A: begin
						if (byte_in == CH_A_UP || byte_in == CH_A_LO) begin
							phase_d = PH_WAIT_T;
							idle_d  = '0;
						end
					end
					PH_WAIT_T: begin
						if (byte_in == CH_T_UP || byte_in == CH_T_LO) begin
							phase_d = PH_LINE;
							count_d = '0;
							name_d  = '0;
							read_d  = 1'b0;
							plain_d = 1'b1;
							idle_d  = '0;
						end else begin
							drop = 1'b1;
						end
					end
					PH_LINE: begin
						idle_d = '0;
						priority if (byte_in == CH_EQ) begin
							plain_d = 1'b0;
							if (count_q == '0) begin
								drop    = 1'b1;
								res.evt = EV_MALFORMED;
							end else begin
								name_d = count_q;
							end
						end else if (byte_in == CH_QM) begin
							if (!plain_q && name_q == count_q) begin
								read_d = 1'b1;
							end else begin
								drop    = 1'b1;
								res.evt = EV_MALFORMED;
							end
						end else if (byte_in == CH_CR) begin
							name_d            = name_ready;
							phase_d           = PH_HOLD;
							res.evt           = EV_READY;
							res.name_length   = nl_w[6:0];
							res.line_length   = ll_w[6:0];
							res.is_read_query = read_q;
							res.is_plain      = plain_q;
						end else if (byte_in == CH_BS) begin
							if (count_q != '0) begin
								count_d      = count_dec;
								if (name_q == count_dec)
									name_d = '0;
								res.evt      = EV_REMOVED;
								res.position = dec_w[5:0];
							end
						end else if (count_q >= CW'(LINE_CAPACITY)) begin
							drop    = 1'b1;
							res.evt = EV_OVERFLOW;
						end else begin
							count_d         = count_q + CW'(1);
							res.evt         = EV_STORED;
							res.stored_byte = byte_in;
							res.position    = pos_w[5:0];
						end
					end
					PH_HOLD: ;
					default: ;
				endcase
			end
			OP_TICK: begin
				if (phase_q == PH_WAIT_T || phase_q == PH_LINE) begin
					idle_d = idle_inc;
					if (idle_inc > timeout_ticks) begin
						drop    = 1'b1;
						res.evt = EV_TIMEOUT;
					end
				end
			end
			OP_RELEASE: begin
				if (phase_q == PH_HOLD)
					drop = 1'b1;
			end
			default: ;
		endcase

		// abandon the line and return to waiting for the prefix
		if (drop) begin
			phase_d = PH_WAIT_A;
			count_d = '0;
			name_d  = '0;
			read_d  = 1'b0;
			plain_d = 1'b1;
			idle_d  = '0;
		end
	end

endmodule

>>> hw/rtl/atcl_out_stage.sv
// Result register with stream handshake toward the consumer.
module atcl_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  atcl_pkg::result_t res,
	output logic              load_ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,
	output logic [7:0]        m_tuser
);
	import atcl_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign load_ready = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ready)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.is_plain, res_s2.is_read_query, res_s2.line_length,
		res_s2.name_length, res_s2.position, res_s2.stored_byte};
	assign m_tuser  = {5'b00000, res_s2.evt};

endmodule

>>> hw/rtl/atcl_checker.sv
// Port-level checks for the AT command line receiver, bound to the top level.
module atcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [7:0]  m_tuser
);
	import atcl_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_byte_only_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] != EV_STORED |-> m_tdata[7:0] == 8'd0)
		else $error("stored_byte set on non-store event");

	a_pos_only_on_edit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] != EV_STORED && m_tuser[2:0] != EV_REMOVED
		|-> m_tdata[13:8] == 6'd0)
		else $error("position set on non-edit event");

	a_ready_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] != EV_READY |-> m_tdata[31:14] == 18'd0)
		else $error("command fields set outside command ready");

	a_query_not_plain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == EV_READY |-> !(m_tdata[28] && m_tdata[29]))
		else $error("read query reported on a plain command");

endmodule

bind at_command_line_receiver_top atcl_checker u_atcl_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
